>>> src/ipchk_pkg.sv
// Shared types and constants for the IP address string check unit.
`default_nettype none

package ipchk_pkg;

    // Default depth of the word queue between the front and back parts.
    localparam int QueueDepthDefault = 2;

    // Characters that the classifier picks out.
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_BRACKET = 8'h5B;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_LOW_A   = 8'h61;
    localparam logic [7:0] CHAR_LOW_F   = 8'h66;
    localparam logic [7:0] CHAR_UP_A    = 8'h41;
    localparam logic [7:0] CHAR_UP_F    = 8'h46;

    // Class of one input byte as seen by the recognizers.
    typedef enum logic [2:0] {
        KIND_END     = 3'd0,
        KIND_COLON   = 3'd1,
        KIND_DOT     = 3'd2,
        KIND_DIGIT   = 3'd3,
        KIND_HEX     = 3'd4,
        KIND_BRACKET = 3'd5,
        KIND_OTHER   = 3'd6
    } kind_t;

    // A classified byte: its class and, for decimal digits, the digit value.
    typedef struct packed {
        kind_t      kind;
        logic [3:0] digit;
    } token_t;

endpackage

`default_nettype wire

>>> src/ip_address_string_check_unit.sv
// Top level of the IP address string check unit.
// The unit reads a text string one byte per word on the input channel and,
// when a zero byte arrives, delivers one output word whose is_address bit
// tells whether the text is a numeric IPv4 address, an IPv6 address or
// starts with a '[' bracket; all other bytes produce no output. One byte
// is accepted every clock cycle as long as the output side keeps up. A
// byte passes through the classifier register, the word queue and the
// recognizer stage in that order, and the recognizer registers the
// verdict for a string when it takes the zero byte of that string. The
// recognizer state lives in small counters and flags that are updated
// once per byte, which is what limits the rate to one byte per cycle.
// The QueueDepth words of queue let the front keep accepting bytes for a
// while after the output side starts to stall.
`default_nettype none

module ip_address_string_check_unit
#(
    parameter int QueueDepth = ipchk_pkg::QueueDepthDefault
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] char_code,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            is_address
);
    import ipchk_pkg::*;

    // Classified byte leaving the front part.
    logic   front_valid;
    logic   front_stall;
    token_t front_tok;

    // Word at the head of the queue, offered to the back part.
    logic   back_valid;
    logic   back_stall;
    token_t back_tok;

    // The front part turns each byte into a token and holds it in a register.
    ipchk_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .tok_valid (front_valid),
        .tok_stall (front_stall),
        .tok       (front_tok)
    );

    // The queue lets the front keep taking bytes while the verdict waits.
    ipchk_queue #(
        .Depth (QueueDepth)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_stall (front_stall),
        .wr_tok   (front_tok),
        .rd_valid (back_valid),
        .rd_stall (back_stall),
        .rd_tok   (back_tok)
    );

    // The back part runs both recognizers and owns the output register.
    ipchk_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .tok_valid  (back_valid),
        .tok_stall  (back_stall),
        .tok        (back_tok),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .is_address (is_address)
    );

endmodule

`default_nettype wire

>>> src/ipchk_front.sv
// Front part: accepts bytes and classifies them into tokens.
`default_nettype none

module ipchk_front
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [7:0]       char_code,
    output logic                  tok_valid,
    input  wire logic             tok_stall,
    output ipchk_pkg::token_t     tok
);
    import ipchk_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    token_t tok_reg;
    token_t tok_class;
    logic   load;

    always_comb
    begin
        tok_class.digit = char_code[3:0];
        if (char_code == CHAR_NUL)
        begin
            tok_class.kind = KIND_END;
        end
        else if (char_code == CHAR_COLON)
        begin
            tok_class.kind = KIND_COLON;
        end
        else if (char_code == CHAR_DOT)
        begin
            tok_class.kind = KIND_DOT;
        end
        else if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE)
        begin
            tok_class.kind = KIND_DIGIT;
        end
        else if ((char_code >= CHAR_LOW_A && char_code <= CHAR_LOW_F) ||
                 (char_code >= CHAR_UP_A && char_code <= CHAR_UP_F))
        begin
            tok_class.kind = KIND_HEX;
        end
        else if (char_code == CHAR_BRACKET)
        begin
            tok_class.kind = KIND_BRACKET;
        end
        else
        begin
            tok_class.kind = KIND_OTHER;
        end
    end

    assign in_stall = valid_reg && tok_stall;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!tok_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tok_reg <= tok_class;
        end
    end

    assign tok_valid = valid_reg;
    assign tok       = tok_reg;

endmodule

`default_nettype wire

>>> src/ipchk_queue.sv
// Small word queue that decouples the front part from the back part.
`default_nettype none

module ipchk_queue
#(
    parameter int Depth = ipchk_pkg::QueueDepthDefault
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_valid,
    output logic                   wr_stall,
    input  wire ipchk_pkg::token_t wr_tok,
    output logic                   rd_valid,
    input  wire logic              rd_stall,
    output ipchk_pkg::token_t      rd_tok
);
    import ipchk_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    token_t            mem_reg [Depth];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_next;
    logic [CntW-1:0]   count_reg;
    logic [CntW-1:0]   count_next;
    logic              push;
    logic              pop;

    assign wr_stall = (count_reg == CntW'(Depth));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;
    assign rd_tok   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_tok;
        end
    end

endmodule

`default_nettype wire

>>> src/ipchk_back.sv
// Back part: runs the IPv6 and IPv4 recognizers and registers the verdict.
`default_nettype none

module ipchk_back
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              tok_valid,
    output logic                   tok_stall,
    input  wire ipchk_pkg::token_t tok,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   is_address
);
    import ipchk_pkg::*;

    localparam logic [3:0] ColonSat   = 4'd15;
    localparam logic [3:0] ColonMax   = 4'd7;
    localparam logic [2:0] HexMax     = 3'd4;
    localparam logic [1:0] DigitMax   = 2'd3;
    localparam logic [2:0] DotsSat    = 3'd7;
    localparam logic [2:0] DotsNeeded = 3'd3;
    localparam logic [9:0] OctetMax   = 10'd255;
    localparam logic [9:0] OctetSat   = 10'd1023;

    typedef enum logic [1:0] {
        DECIDE_NONE = 2'd0,
        DECIDE_YES  = 2'd1,
        DECIDE_NO   = 2'd2
    } decide_t;

    logic       at_start_reg,   at_start_next;
    decide_t    decided_reg,    decided_next;
    logic       dot_seen_reg,   dot_seen_next;
    logic       v6_fail_reg,    v6_fail_next;
    logic [3:0] colons_reg,     colons_next;
    logic [2:0] hex_run_reg,    hex_run_next;
    logic       lone_reg,       lone_next;
    logic       dbl_used_reg,   dbl_used_next;
    logic       v4_fail_reg,    v4_fail_next;
    logic [2:0] dots_reg,       dots_next;
    logic [1:0] digit_run_reg,  digit_run_next;
    logic [9:0] octet_reg,      octet_next;
    logic       prev_dot_reg,   prev_dot_next;
    logic       out_valid_reg,  out_valid_next;
    logic       is_address_reg, is_address_next;

    logic        take;
    logic        verdict;
    logic [13:0] octet_prod;

    assign tok_stall = tok_valid && (tok.kind == KIND_END) && out_valid_reg && out_stall;
    assign take      = tok_valid && !tok_stall;

    always_comb
    begin
        if (decided_reg == DECIDE_YES)
        begin
            verdict = 1'b1;
        end
        else if (decided_reg != DECIDE_NONE || v6_fail_reg)
        begin
            verdict = 1'b0;
        end
        else if (!dot_seen_reg && colons_reg > ColonMax)
        begin
            verdict = 1'b0;
        end
        else if (!dot_seen_reg && colons_reg > 4'd1)
        begin
            verdict = 1'b1;
        end
        else
        begin
            verdict = !v4_fail_reg && (octet_reg <= OctetMax) && (dots_reg == DotsNeeded);
        end
    end

    assign octet_prod = {4'b0, octet_reg} * 14'd10 + {10'b0, tok.digit};

    always_comb
    begin
        at_start_next   = at_start_reg;
        decided_next    = decided_reg;
        dot_seen_next   = dot_seen_reg;
        v6_fail_next    = v6_fail_reg;
        colons_next     = colons_reg;
        hex_run_next    = hex_run_reg;
        lone_next       = lone_reg;
        dbl_used_next   = dbl_used_reg;
        v4_fail_next    = v4_fail_reg;
        dots_next       = dots_reg;
        digit_run_next  = digit_run_reg;
        octet_next      = octet_reg;
        prev_dot_next   = prev_dot_reg;
        out_valid_next  = out_valid_reg && out_stall;
        is_address_next = is_address_reg;

        if (take)
        begin
            if (tok.kind == KIND_END)
            begin
                out_valid_next  = 1'b1;
                is_address_next = verdict;
                at_start_next   = 1'b1;
                decided_next    = DECIDE_NONE;
                dot_seen_next   = 1'b0;
                v6_fail_next    = 1'b0;
                colons_next     = '0;
                hex_run_next    = '0;
                lone_next       = 1'b0;
                dbl_used_next   = 1'b0;
                v4_fail_next    = 1'b0;
                dots_next       = '0;
                digit_run_next  = '0;
                octet_next      = '0;
                prev_dot_next   = 1'b0;
            end
            else if (at_start_reg && tok.kind == KIND_BRACKET)
            begin
                at_start_next = 1'b0;
                decided_next  = DECIDE_YES;
            end
            else if (at_start_reg && tok.kind == KIND_DOT)
            begin
                at_start_next = 1'b0;
                decided_next  = DECIDE_NO;
            end
            else if (decided_reg == DECIDE_NONE)
            begin
                at_start_next = 1'b0;

                // IPv6 recognizer, active until the first dot or a fatal fault.
                if (!dot_seen_reg && !v6_fail_reg)
                begin
                    if (tok.kind == KIND_COLON)
                    begin
                        if (lone_reg)
                        begin
                            if (dbl_used_reg)
                            begin
                                v6_fail_next = 1'b1;
                            end
                            dbl_used_next = 1'b1;
                            lone_next     = 1'b0;
                        end
                        else
                        begin
                            lone_next = 1'b1;
                        end
                        if (colons_reg < ColonSat)
                        begin
                            colons_next = colons_reg + 1'b1;
                        end
                        hex_run_next = '0;
                    end
                    else
                    begin
                        lone_next = 1'b0;
                        if (tok.kind == KIND_DOT)
                        begin
                            dot_seen_next = 1'b1;
                        end
                        else if (tok.kind != KIND_DIGIT && tok.kind != KIND_HEX)
                        begin
                            v6_fail_next = 1'b1;
                        end
                        else if (hex_run_reg >= HexMax)
                        begin
                            v6_fail_next = 1'b1;
                        end
                        else
                        begin
                            hex_run_next = hex_run_reg + 1'b1;
                        end
                    end
                end

                // Dotted IPv4 recognizer, active for every byte while no early decision holds.
                if (tok.kind == KIND_DOT)
                begin
                    if (prev_dot_reg || octet_reg > OctetMax)
                    begin
                        v4_fail_next = 1'b1;
                    end
                    if (dots_reg < DotsSat)
                    begin
                        dots_next = dots_reg + 1'b1;
                    end
                    digit_run_next = '0;
                    octet_next     = '0;
                    prev_dot_next  = 1'b1;
                end
                else
                begin
                    prev_dot_next = 1'b0;
                    if (tok.kind != KIND_DIGIT)
                    begin
                        v4_fail_next = 1'b1;
                    end
                    else
                    begin
                        if (digit_run_reg >= DigitMax)
                        begin
                            v4_fail_next = 1'b1;
                        end
                        else
                        begin
                            digit_run_next = digit_run_reg + 1'b1;
                        end
                        octet_next = (octet_prod > {4'b0, OctetSat}) ? OctetSat
                                                                   : octet_prod[9:0];
                    end
                end
            end
            else
            begin
                at_start_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_start_reg  <= 1'b1;
            decided_reg   <= DECIDE_NONE;
            dot_seen_reg  <= 1'b0;
            v6_fail_reg   <= 1'b0;
            colons_reg    <= '0;
            hex_run_reg   <= '0;
            lone_reg      <= 1'b0;
            dbl_used_reg  <= 1'b0;
            v4_fail_reg   <= 1'b0;
            dots_reg      <= '0;
            digit_run_reg <= '0;
            octet_reg     <= '0;
            prev_dot_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            at_start_reg  <= at_start_next;
            decided_reg   <= decided_next;
            dot_seen_reg  <= dot_seen_next;
            v6_fail_reg   <= v6_fail_next;
            colons_reg    <= colons_next;
            hex_run_reg   <= hex_run_next;
            lone_reg      <= lone_next;
            dbl_used_reg  <= dbl_used_next;
            v4_fail_reg   <= v4_fail_next;
            dots_reg      <= dots_next;
            digit_run_reg <= digit_run_next;
            octet_reg     <= octet_next;
            prev_dot_reg  <= prev_dot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_address_reg <= is_address_next;
    end

    assign out_valid  = out_valid_reg;
    assign is_address = is_address_reg;

endmodule

`default_nettype wire

>>> tb/sv/ip_address_string_check_unit_test.sv
// Self-checking testbench for the IP address string check unit.
`timescale 1ns / 1ps

module ip_address_string_check_unit_test;

    import ipchk_pkg::*;

    localparam time CLK_HALF     = 2ns;
    localparam int  RESET_CYCLES = 9;
    localparam int  TAIL_CYCLES  = 12;
    localparam int  DRAIN_LIMIT  = 4000;
    localparam int  TOTAL_WORDS  = 1800;
    localparam int  LONG_HOLD    = 300;
    localparam time RUN_LIMIT    = 3_000_000ns;

    // Limits of the address grammar.
    localparam int OCTET_LIMIT   = 255;
    localparam int OCTET_CAP     = 1023;
    localparam int COLON_LIMIT   = 7;
    localparam int COLON_CAP     = 15;
    localparam int DOT_CAP       = 7;
    localparam int DOTS_NEEDED   = 3;
    localparam int HEX_GROUP_LEN = 4;
    localparam int OCTET_LEN     = 3;

    typedef enum logic [1:0] {
        EARLY_NONE = 2'd0,
        EARLY_YES  = 2'd1,
        EARLY_NO   = 2'd2
    } early_t;

    typedef struct {
        bit         at_start;
        early_t     early;
        bit         dot_seen;
        bit         v6_failed;
        logic [3:0] colons;
        logic [2:0] hex_run;
        bit         lone_colon;
        bit         double_used;
        bit         v4_failed;
        logic [2:0] dots;
        logic [2:0] digit_run;
        logic [9:0] octet;
        bit         prev_dot;
    } scan_state_t;

    typedef struct {
        logic verdict;
        int   text_id;
    } expected_verdict_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [7:0] char_code;
    logic out_valid;
    logic out_stall;
    logic is_address;

    scan_state_t       scan;
    expected_verdict_t pending_verdicts[$];
    logic [7:0]        text_buf[$];
    int                text_count;
    int                sent_words;
    int                error_count;
    int                long_hold_cycles;
    bit                sender_gaps_on;
    string             hex_chars  = "0123456789abcdefABCDEF";
    string             text_chars = "0123456789abcdefABCDEF:.[";

    ip_address_string_check_unit u_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_code  (char_code),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .is_address (is_address)
    );

    always #(CLK_HALF) clk = ~clk;

    initial
    begin
        #(RUN_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // ---------------------------------------------------------------- prediction

    function automatic bit is_dec(input logic [7:0] c);
        return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    function automatic bit is_hex(input logic [7:0] c);
        return is_dec(c) || (c >= CHAR_LOW_A && c <= CHAR_LOW_F)
            || (c >= CHAR_UP_A && c <= CHAR_UP_F);
    endfunction

    function automatic void scan_clear();
        scan.at_start    = 1'b1;
        scan.early       = EARLY_NONE;
        scan.dot_seen    = 1'b0;
        scan.v6_failed   = 1'b0;
        scan.colons      = '0;
        scan.hex_run     = '0;
        scan.lone_colon  = 1'b0;
        scan.double_used = 1'b0;
        scan.v4_failed   = 1'b0;
        scan.dots        = '0;
        scan.digit_run   = '0;
        scan.octet       = '0;
        scan.prev_dot    = 1'b0;
    endfunction

    function automatic void scan_v6(input logic [7:0] c);
        if (scan.dot_seen || scan.v6_failed)
            return;
        if (c == CHAR_COLON)
        begin
            if (scan.lone_colon)
            begin
                // A second double colon is fatal.
                if (scan.double_used)
                    scan.v6_failed = 1'b1;
                scan.double_used = 1'b1;
                scan.lone_colon  = 1'b0;
            end
            else
            begin
                scan.lone_colon = 1'b1;
            end
            if (scan.colons < COLON_CAP)
                scan.colons = scan.colons + 4'd1;
            scan.hex_run = '0;
            return;
        end
        scan.lone_colon = 1'b0;
        if (c == CHAR_DOT)
        begin
            scan.dot_seen = 1'b1;
            return;
        end
        if (!is_hex(c))
        begin
            scan.v6_failed = 1'b1;
            return;
        end
        if (scan.hex_run >= HEX_GROUP_LEN)
            scan.v6_failed = 1'b1;
        else
            scan.hex_run = scan.hex_run + 3'd1;
    endfunction

    function automatic void scan_v4(input logic [7:0] c);
        int acc;
        if (c == CHAR_DOT)
        begin
            if (scan.prev_dot || scan.octet > OCTET_LIMIT)
                scan.v4_failed = 1'b1;
            if (scan.dots < DOT_CAP)
                scan.dots = scan.dots + 3'd1;
            scan.digit_run = '0;
            scan.octet     = '0;
            scan.prev_dot  = 1'b1;
            return;
        end
        scan.prev_dot = 1'b0;
        if (!is_dec(c))
        begin
            scan.v4_failed = 1'b1;
            return;
        end
        if (scan.digit_run >= OCTET_LEN)
            scan.v4_failed = 1'b1;
        else
            scan.digit_run = scan.digit_run + 3'd1;
        acc = int'(scan.octet) * 10 + int'(c - CHAR_ZERO);
        scan.octet = (acc > OCTET_CAP) ? 10'(OCTET_CAP) : 10'(acc);
    endfunction

    function automatic logic scan_verdict();
        if (scan.early == EARLY_YES)
            return 1'b1;
        if (scan.early != EARLY_NONE)
            return 1'b0;
        if (scan.v6_failed)
            return 1'b0;
        if (!scan.dot_seen && scan.colons > COLON_LIMIT)
            return 1'b0;
        if (!scan.dot_seen && scan.colons > 1)
            return 1'b1;
        return !scan.v4_failed && scan.octet <= OCTET_LIMIT && scan.dots == DOTS_NEEDED;
    endfunction

    // Advances the predicted state by one byte; a zero byte yields a verdict.
    function automatic void scan_char(input logic [7:0] c, output bit done, output logic verdict);
        done    = 1'b0;
        verdict = 1'b0;
        if (c == CHAR_NUL)
        begin
            done    = 1'b1;
            verdict = scan_verdict();
            scan_clear();
            return;
        end
        if (scan.at_start)
        begin
            scan.at_start = 1'b0;
            if (c == CHAR_BRACKET)
            begin
                scan.early = EARLY_YES;
                return;
            end
            if (c == CHAR_DOT)
            begin
                scan.early = EARLY_NO;
                return;
            end
        end
        if (scan.early != EARLY_NONE)
            return;
        scan_v6(c);
        scan_v4(c);
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    always @(posedge clk)
    begin : check_results
        expected_verdict_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_verdicts.size() == 0)
            begin
                report_mismatch($sformatf("result word %0b with nothing expected", is_address));
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (is_address !== want.verdict)
                    report_mismatch($sformatf("string %0d: is_address %0b, expected %0b",
                                              want.text_id, is_address, want.verdict));
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 1;
        if (r < 90)
            return $urandom_range(2, 4);
        return $urandom_range(5, 30);
    endfunction

    // The receiver alternates free stretches with stalls; a long hold request
    // from a test is counted out here.
    initial
    begin : receiver
        int stall_left;
        int free_left;
        out_stall  = 1'b0;
        stall_left = 0;
        free_left  = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (long_hold_cycles) @(negedge clk);
                long_hold_cycles = 0;
                out_stall <= 1'b0;
                free_left = 20;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (free_left > 0)
            begin
                out_stall <= 1'b0;
                free_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                free_left  = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(0, 12);
                stall_left = pick_idle();
            end
        end
    end

    // ---------------------------------------------------------------- sender

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Entered and left just after a falling edge; valid stays high on return
    // so that a following word goes out without a bubble.
    task automatic send_byte(input logic [7:0] c);
        int   gap;
        bit   done;
        logic verdict;
        gap = sender_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sent_words++;
        scan_char(c, done, verdict);
        if (done)
            pending_verdicts.push_back('{verdict: verdict, text_id: text_count});
        @(negedge clk);
    endtask

    task automatic send_buffer();
        text_count++;
        foreach (text_buf[i])
            send_byte(text_buf[i]);
        send_byte(CHAR_NUL);
    endtask

    task automatic sender_idle();
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        sender_idle();
        while (pending_verdicts.size() != 0)
            @(negedge clk);
    endtask

    // ---------------------------------------------------------------- text builders

    function automatic void append_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endfunction

    task automatic send_text(input string s);
        text_buf.delete();
        append_text(s);
        send_buffer();
    endtask

    function automatic logic [7:0] rand_text_byte();
        if ($urandom_range(0, 1) == 0)
            return text_chars[$urandom_range(0, text_chars.len() - 1)];
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic void append_ipv4();
        int r;
        for (int k = 0; k < 4; k++)
        begin
            if (k > 0)
                text_buf.push_back(CHAR_DOT);
            r = $urandom_range(0, 99);
            if (k == 3 && r < 8)
                continue;       // empty last octet
            if (r < 15)
                append_text($sformatf("%0d", (r < 10) ? OCTET_LIMIT : 0));
            else if (r < 75)
                append_text($sformatf("%0d", $urandom_range(0, 255)));
            else if (r < 85)
                append_text($sformatf("%03d", $urandom_range(0, 99)));
            else if (r < 94)
                append_text($sformatf("%0d", $urandom_range(256, 999)));
            else
                append_text($sformatf("%0d", $urandom_range(1000, 99999)));
        end
    endfunction

    function automatic void append_ipv6();
        int groups;
        int dbl;
        int dbl2;
        int ncol;
        int len;
        groups = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : $urandom_range(3, 8);
        dbl    = ($urandom_range(0, 9) < 4) ? $urandom_range(0, groups - 1) : -1;
        dbl2   = ($urandom_range(0, 19) == 0) ? $urandom_range(0, groups - 1) : -1;
        for (int g = 0; g < groups; g++)
        begin
            ncol = (g > 0) ? 1 : 0;
            if (g == dbl || g == dbl2)
                ncol = 2;
            repeat (ncol) text_buf.push_back(CHAR_COLON);
            len = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) == 0) ? 0 : 5)
                                              : $urandom_range(1, 4);
            repeat (len) text_buf.push_back(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
        end
        if ($urandom_range(0, 9) == 0)
            append_text("::");
        if ($urandom_range(0, 9) == 0)
        begin
            text_buf.push_back(CHAR_COLON);
            append_ipv4();
        end
    endfunction

    function automatic void mutate_text();
        int pos;
        pos = $urandom_range(0, text_buf.size());
        case ($urandom_range(0, 3))
            0: text_buf.insert(pos, rand_text_byte());
            1: if (pos < text_buf.size()) text_buf.delete(pos);
            2: if (pos < text_buf.size()) text_buf[pos] = rand_text_byte();
            default: text_buf.insert(pos, ($urandom_range(0, 1) == 0) ? CHAR_DOT : CHAR_COLON);
        endcase
    endfunction

    // Builds one random string in the text buffer.
    function automatic void build_random_text();
        int r;
        text_buf.delete();
        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            append_ipv4();
        end
        else if (r < 65)
        begin
            append_ipv6();
        end
        else if (r < 75)
        begin
            text_buf.push_back(($urandom_range(0, 1) == 0) ? CHAR_BRACKET : CHAR_DOT);
            repeat ($urandom_range(0, 5)) text_buf.push_back(rand_text_byte());
        end
        else if (r < 85)
        begin
            repeat ($urandom_range(0, 10)) text_buf.push_back(rand_text_byte());
        end
        else
        begin
            if ($urandom_range(0, 1) == 0)
                append_ipv4();
            else
                append_ipv6();
            repeat ($urandom_range(1, 2)) mutate_text();
        end
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_early_decisions();
        send_text("");
        send_text("[");
        send_text("[zz");
        send_text(".");
        send_text(".1.2.3");
    endtask

    task automatic test_ipv4_rules();
        send_text("0.0.0.0");
        send_text("255.255.255.255");
        send_text("256.1.1.1");
        send_text("1.1.1.256");
        send_text("1.2.3.");
        send_text("1..2.3");
        send_text("1.2.3.4.5");
        send_text("1.2.3");
        send_text("1234.1.1.1");
        send_text("99999.1.1.1");
    endtask

    task automatic test_ipv6_rules();
        send_text("::");
        send_text("::1");
        send_text("1::2::3");
        send_text("1:2:3:4:5:6:7:8");
        send_text("1:2:3:4:5:6:7:8:9");
        send_text("a:b");
        send_text("12345::");
        send_text("ABCD:ef::g");
        send_text("::ffff:1.2.3.4");
    endtask

    task automatic test_high_bytes();
        text_buf.delete();
        text_buf.push_back(8'hFF);
        send_buffer();
        text_buf.delete();
        append_text("1.2.3.");
        text_buf.push_back(8'h80);
        send_buffer();
        text_buf.delete();
        text_buf.push_back(CHAR_BRACKET);
        text_buf.push_back(8'hFF);
        send_buffer();
    endtask

    // Random strings fill up the run until the total word budget is spent.
    task automatic test_random_strings();
        int strings;
        strings = 0;
        while (sent_words < TOTAL_WORDS)
        begin
            sender_gaps_on = ($urandom_range(0, 3) != 0);
            build_random_text();
            send_buffer();
            strings++;
            if (strings % 50 == 0)
                wait_for_drain();
        end
        sender_gaps_on = 1'b1;
    endtask

    // The receiver holds off while the sender keeps offering words back to
    // back, so the queue fills and the input must stall.
    task automatic test_output_backpressure();
        sender_gaps_on   = 1'b0;
        long_hold_cycles = LONG_HOLD;
        repeat (40)
        begin
            text_buf.delete();
            append_ipv4();
            send_buffer();
        end
        sender_gaps_on = 1'b1;
    endtask

    // The sender goes quiet until every verdict is out, then resumes.
    task automatic test_sender_pause();
        repeat (5)
        begin
            build_random_text();
            send_buffer();
        end
        wait_for_drain();
        repeat ($urandom_range(1, 20)) @(negedge clk);
        repeat (5)
        begin
            build_random_text();
            send_buffer();
        end
    endtask

    // ---------------------------------------------------------------- main

    initial
    begin : main
        int waited;
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        char_code        = 8'h00;
        sender_gaps_on   = 1'b1;
        long_hold_cycles = 0;
        text_count       = 0;
        sent_words       = 0;
        error_count      = 0;
        scan_clear();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_early_decisions();
        test_ipv4_rules();
        test_ipv6_rules();
        test_high_bytes();
        test_output_backpressure();
        test_sender_pause();
        test_random_strings();

        sender_idle();
        waited = 0;
        while (pending_verdicts.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(negedge clk);
        if (pending_verdicts.size() != 0)
            report_mismatch($sformatf("%0d verdicts never arrived", pending_verdicts.size()));

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
